// ===== hw/rtl/bba_pkg.sv =====
// ============================================================================
// bba_pkg
// Shared codes and field widths for the buddy block allocator.
// ============================================================================
package bba_pkg;

  // Field widths of the input and result beats
  localparam int unsigned REQ_W    = 11;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned STATUS_W = 2;
  // A rounded request may reach 2**REQ_W, one above the largest request field value
  localparam int unsigned WANT_W   = REQ_W + 1;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [OFF_W-1:0]    off_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [WANT_W-1:0]   want_t;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_IGNORED = 2'd2;

endpackage

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// ============================================================================
// buddy_block_allocator_core
// Buddy allocator over TOTAL_BLOCKS blocks, free-run tree held in one RAM.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: allocate
//   in_request_blocks (rounded up to a power of two, zero counts as one) or
//   free the run that covers in_free_offset. Every command returns exactly
//   one result beat on out_valid / out_stall: the granted block offset (zero
//   otherwise) and a status (ok, no space, free ignored).
//   The tree of largest free runs lives in a RAM with two registered read
//   ports and one write port. An allocate reads the root, descends one level
//   per cycle reading both children, marks the node and climbs back one
//   level per cycle reading the sibling and writing the parent. A free
//   climbs from the leaf one level per cycle, then merges upward the same way.
//   One command at a time. After reset the block runs a clearing pass,
//   writing each node's full range size, with in_stall held high.
//   A finished result sits in the output register while the receiver
//   stalls; the next command is taken once the walk returns to idle, and
//   its result waits until the output register drains.
// ============================================================================
module buddy_block_allocator_core
  import bba_pkg::*;
#(
  parameter int unsigned TOTAL_BLOCKS = 1024
)
(
  input  logic    clk,
  input  logic    rst_n,
  // command channel
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    in_command,
  input  req_t    in_request_blocks,
  input  off_t    in_free_offset,
  // result channel
  output logic    out_valid,
  input  logic    out_stall,
  output off_t    out_block_offset,
  output status_t out_status
);

  // Tree geometry derived from the pool size
  localparam int unsigned LVL_W = $clog2(TOTAL_BLOCKS);
  localparam int unsigned NW    = LVL_W + 1;            // node index width
  localparam int unsigned VW    = LVL_W + 1;            // node value width
  localparam int unsigned NODES = 2 * TOTAL_BLOCKS - 1;
  localparam int unsigned CW    = (VW > WANT_W) ? VW : WANT_W;
  localparam int unsigned EW    = (NW > OFF_W) ? NW : OFF_W;

  localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);
  localparam logic [NW-1:0] LEAF_BASE = NW'(TOTAL_BLOCKS - 1);
  localparam logic [VW-1:0] ROOT_SPAN = VW'(TOTAL_BLOCKS);

  // Controller states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_A_CHK  = 3'd2;
  localparam logic [2:0] S_A_DESC = 3'd3;
  localparam logic [2:0] S_F_UP   = 3'd4;
  localparam logic [2:0] S_MARK   = 3'd5;
  localparam logic [2:0] S_CLIMB  = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // --------------------------------------------------------------------------
  // Free-run tree RAM: one write port, two registered read ports.
  // The walk never reads the entry it writes in the same cycle.
  // --------------------------------------------------------------------------
  logic [VW-1:0] tree_mem [NODES];
  logic          mem_we;
  logic [NW-1:0] mem_wa;
  logic [VW-1:0] mem_wd;
  logic [NW-1:0] mem_ra;
  logic [NW-1:0] mem_rb;
  logic [VW-1:0] rda_r;
  logic [VW-1:0] rdb_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_wa] <= mem_wd;
    end
    rda_r <= tree_mem[mem_ra];
    rdb_r <= tree_mem[mem_rb];
  end

  // --------------------------------------------------------------------------
  // Request rounding
  // --------------------------------------------------------------------------
  want_t want_c;

  bba_round_pow2 u_round (
    .req  (in_request_blocks),
    .want (want_c)
  );

  // --------------------------------------------------------------------------
  // Walk registers
  // --------------------------------------------------------------------------
  logic [2:0]       state_r,    state_nxt;
  logic             cmd_r,      cmd_nxt;
  want_t            want_r,     want_nxt;
  logic [NW-1:0]    node_r,     node_nxt;
  logic [VW-1:0]    span_r,     span_nxt;
  logic [VW-1:0]    val_r,      val_nxt;
  logic [LVL_W-1:0] offset_r,   offset_nxt;
  status_t          status_r,   status_nxt;
  logic [NW-1:0]    clr_idx_r,  clr_idx_nxt;
  logic [VW-1:0]    clr_span_r, clr_span_nxt;

  logic             out_valid_r;
  off_t             out_block_offset_r;
  status_t          out_status_r;
  logic             out_load;

  // Combinational helpers
  logic             off_ok;
  logic [NW-1:0]    leaf_idx;
  logic [NW-1:0]    left_idx;
  logic [NW-1:0]    right_idx;
  logic [NW-1:0]    child_idx;
  logic [NW-1:0]    parent_idx;
  logic [NW-1:0]    node_sib;
  logic [NW-1:0]    parent_sib;
  logic [VW-1:0]    span_half;
  logic [VW-1:0]    span_dbl;
  logic [VW-1:0]    merge_val;
  logic [VW:0]      pair_sum;
  logic             go_left;

  always_comb begin
    off_ok    = EW'(in_free_offset) < EW'(TOTAL_BLOCKS);
    leaf_idx  = NW'(in_free_offset) + LEAF_BASE;
    left_idx  = {node_r[NW-2:0], 1'b1};
    right_idx = left_idx + NW'(1);
    // Parent of a non-root node is (n - 1) / 2
    parent_idx = (node_r - NW'(1)) >> 1;
    // Left children have odd indices
    node_sib   = node_r[0] ? node_r + NW'(1) : node_r - NW'(1);
    parent_sib = parent_idx[0] ? parent_idx + NW'(1) : parent_idx - NW'(1);
    span_half  = span_r >> 1;
    span_dbl   = span_r << 1;

    // Descent: take the smaller child that still fits, left on a tie
    if (CW'(rda_r) <= CW'(rdb_r)) begin
      go_left = CW'(rda_r) >= CW'(want_r);
    end else begin
      go_left = !(CW'(rdb_r) >= CW'(want_r));
    end
    child_idx = go_left ? left_idx : right_idx;

    // Climb: plain max on allocate, buddy merge on free
    pair_sum = {1'b0, val_r} + {1'b0, rda_r};
    if (cmd_r == CMD_FREE && pair_sum == {1'b0, span_dbl}) begin
      merge_val = span_dbl;
    end else begin
      merge_val = (val_r > rda_r) ? val_r : rda_r;
    end
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Walk controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    want_nxt     = want_r;
    node_nxt     = node_r;
    span_nxt     = span_r;
    val_nxt      = val_r;
    offset_nxt   = offset_r;
    status_nxt   = status_r;
    clr_idx_nxt  = clr_idx_r;
    clr_span_nxt = clr_span_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    mem_ra       = '0;
    mem_rb       = '0;

    unique case (state_r)
      S_CLEAR: begin
        // Sweep every node with its full range size, level by level
        mem_we      = 1'b1;
        mem_wa      = clr_idx_r;
        mem_wd      = clr_span_r;
        clr_idx_nxt = clr_idx_r + NW'(1);
        if (((clr_idx_nxt + NW'(1)) & clr_idx_nxt) == '0) begin
          clr_span_nxt = clr_span_r >> 1;
        end
        if (clr_idx_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          offset_nxt = '0;
          status_nxt = ST_OK;
          if (in_command == CMD_ALLOC) begin
            // Read the root first
            want_nxt  = want_c;
            node_nxt  = '0;
            span_nxt  = ROOT_SPAN;
            mem_ra    = '0;
            state_nxt = S_A_CHK;
          end else if (!off_ok) begin
            status_nxt = ST_IGNORED;
            state_nxt  = S_OUT;
          end else begin
            node_nxt  = leaf_idx;
            span_nxt  = VW'(1);
            mem_ra    = leaf_idx;
            state_nxt = S_F_UP;
          end
        end
      end

      S_A_CHK: begin
        if (CW'(rda_r) < CW'(want_r)) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_OUT;
        end else if (CW'(span_r) == CW'(want_r)) begin
          state_nxt = S_MARK;
        end else begin
          mem_ra    = left_idx;
          mem_rb    = right_idx;
          state_nxt = S_A_DESC;
        end
      end

      S_A_DESC: begin
        // Children of node_r are in rda_r / rdb_r
        node_nxt = child_idx;
        span_nxt = span_half;
        if (!go_left) begin
          offset_nxt = offset_r + LVL_W'(span_half);
        end
        if (CW'(span_half) == CW'(want_r)) begin
          state_nxt = S_MARK;
        end else begin
          mem_ra = {child_idx[NW-2:0], 1'b1};
          mem_rb = {child_idx[NW-2:0], 1'b1} + NW'(1);
        end
      end

      S_F_UP: begin
        // rda_r holds node_r; stop at the first taken node
        if (rda_r == '0) begin
          state_nxt = S_MARK;
        end else if (node_r == '0) begin
          status_nxt = ST_IGNORED;
          state_nxt  = S_OUT;
        end else begin
          node_nxt = parent_idx;
          span_nxt = span_dbl;
          mem_ra   = parent_idx;
        end
      end

      S_MARK: begin
        mem_we  = 1'b1;
        mem_wa  = node_r;
        mem_wd  = (cmd_r == CMD_ALLOC) ? '0 : span_r;
        val_nxt = mem_wd;
        if (node_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          mem_ra    = node_sib;
          state_nxt = S_CLIMB;
        end
      end

      S_CLIMB: begin
        // rda_r holds the sibling of node_r; rewrite the parent
        mem_we   = 1'b1;
        mem_wa   = parent_idx;
        mem_wd   = merge_val;
        val_nxt  = merge_val;
        node_nxt = parent_idx;
        span_nxt = span_dbl;
        if (parent_idx == '0) begin
          state_nxt = S_OUT;
        end else begin
          mem_ra = parent_sib;
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Take a new command only when the walk is idle
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      clr_span_r  <= ROOT_SPAN;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_span_r <= clr_span_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    want_r   <= want_nxt;
    node_r   <= node_nxt;
    span_r   <= span_nxt;
    val_r    <= val_nxt;
    offset_r <= offset_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_block_offset_r <= OFF_W'(offset_r);
      out_status_r       <= status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_block_offset = out_block_offset_r;
  assign out_status       = out_status_r;

endmodule

// ===== hw/rtl/bba_round_pow2.sv =====
// ============================================================================
// bba_round_pow2
// Rounds a block request up to the next power of two; zero counts as one.
// ============================================================================
module bba_round_pow2
  import bba_pkg::*;
(
  input  req_t  req,
  output want_t want
);

  req_t req_m1;
  req_t smear;

  // Smear the highest set bit of (req - 1) downward, then add one
  always_comb begin
    req_m1 = (req == '0) ? '0 : req - REQ_W'(1);
    smear  = req_m1;
    smear  = smear | (smear >> 1);
    smear  = smear | (smear >> 2);
    smear  = smear | (smear >> 4);
    smear  = smear | (smear >> 8);
    want   = {1'b0, smear} + WANT_W'(1);
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator core testbench
// Sends allocate and free commands through the valid/stall command channel and
// checks each result beat against a software copy of the free-run tree. The
// stimulus starts with a short directed run and continues with random commands.
// Most random frees target runs that are still held. Both sides idle at random,
// and the receiver takes one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_BLOCKS = 1024;
  localparam int unsigned NODES        = 2 * TOTAL_BLOCKS - 1;
  localparam int unsigned LEVELS       = $clog2(TOTAL_BLOCKS);
  localparam int unsigned RANDOM_CMDS  = 1930;
  localparam int unsigned HOLD_CYCLES  = 400;

  // Largest free run below a node; 11 bits are enough for the root size
  typedef bit [REQ_W-1:0] run_len_t;

  typedef struct {
    off_t    offset;
    status_t status;
  } grant_t;

  typedef struct {
    int unsigned base;
    int unsigned span;
  } run_t;

  // Tracks the free-run tree, the runs handed out and the results still owed
  class buddy_tracker;
    run_len_t    free_run [NODES];
    grant_t      owed_grants [$];
    run_t        held_runs [$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
      // Fill every level with its full range size
      for (int unsigned lvl = 0; lvl <= LEVELS; lvl++) begin
        for (int unsigned n = (1 << lvl) - 1; n < (2 << lvl) - 1; n++) begin
          free_run[n] = run_len_t'(TOTAL_BLOCKS >> lvl);
        end
      end
    endfunction

    function grant_t predict_alloc(req_t req);
      grant_t      g;
      int unsigned want;
      int unsigned node;
      int unsigned span;
      int unsigned l;
      int unsigned r;
      run_t        run;
      want = 1;
      while (want < req) want = want << 1;
      g.offset = '0;
      if (free_run[0] < want) begin
        g.status = ST_NOSPACE;
        return g;
      end
      // Descend into the tighter child that still fits, left on a tie
      node = 0;
      span = TOTAL_BLOCKS;
      while (span != want && span > 1) begin
        l = free_run[2 * node + 1];
        r = free_run[2 * node + 2];
        if (l <= r) node = (l >= want) ? 2 * node + 1 : 2 * node + 2;
        else        node = (r >= want) ? 2 * node + 2 : 2 * node + 1;
        span = span >> 1;
      end
      free_run[node] = '0;
      run.base = (node + 1) * span - TOTAL_BLOCKS;
      run.span = span;
      held_runs.push_back(run);
      while (node != 0) begin
        node = (node - 1) / 2;
        l = free_run[2 * node + 1];
        r = free_run[2 * node + 2];
        free_run[node] = run_len_t'((l > r) ? l : r);
      end
      g.offset = off_t'(run.base);
      g.status = ST_OK;
      return g;
    endfunction

    function grant_t predict_free(off_t off);
      grant_t      g;
      int unsigned node;
      int unsigned span;
      int unsigned base;
      int unsigned l;
      int unsigned r;
      g.offset = '0;
      // A 10-bit offset always lands inside a 1024-block pool
      node = off + TOTAL_BLOCKS - 1;
      span = 1;
      while (free_run[node] != 0) begin
        span = span << 1;
        if (node == 0) begin
          g.status = ST_IGNORED;
          return g;
        end
        node = (node - 1) / 2;
      end
      free_run[node] = run_len_t'(span);
      base = (node + 1) * span - TOTAL_BLOCKS;
      foreach (held_runs[i]) begin
        if (held_runs[i].base == base && held_runs[i].span == span) begin
          held_runs.delete(i);
          break;
        end
      end
      // Merge buddies that are both whole again
      while (node != 0) begin
        node = (node - 1) / 2;
        span = span << 1;
        l = free_run[2 * node + 1];
        r = free_run[2 * node + 2];
        free_run[node] = run_len_t'((l + r == span) ? span : ((l > r) ? l : r));
      end
      g.status = ST_OK;
      return g;
    endfunction

    function void note_command(logic cmd, req_t req, off_t off);
      if (cmd == CMD_ALLOC) owed_grants.push_back(predict_alloc(req));
      else                  owed_grants.push_back(predict_free(off));
    endfunction

    function void check_result(off_t got_off, status_t got_status);
      grant_t g;
      if (owed_grants.size() == 0) begin
        $error("unexpected result beat: block_offset %0d status %0d", got_off, got_status);
        fail_count++;
        return;
      end
      g = owed_grants.pop_front();
      if (got_off !== g.offset) begin
        $error("block_offset expected %0d actual %0d", g.offset, got_off);
        fail_count++;
      end
      if (got_status !== g.status) begin
        $error("status expected %0d actual %0d", g.status, got_status);
        fail_count++;
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  logic    in_command;
  req_t    in_request_blocks;
  off_t    in_free_offset;
  logic    out_valid;
  logic    out_stall;
  off_t    out_block_offset;
  status_t out_status;

  buddy_tracker tracker = new();

  // Steady stretch: neither side idles while set
  bit steady;
  // Ask the receiver for one long hold-off
  bit hold_pending;

  buddy_block_allocator_core #(
    .TOTAL_BLOCKS(TOTAL_BLOCKS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_request_blocks(in_request_blocks),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_block_offset (out_block_offset),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one command beat and hold it until the core takes it.
  // Call at a falling edge; return at the falling edge after acceptance.
  task automatic send_command(input logic cmd, input req_t req, input off_t off);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_request_blocks <= req;
    in_free_offset    <= off;
    do @(posedge clk); while (in_stall);
    tracker.note_command(cmd, req, off);
    @(negedge clk);
  endtask

  // Fill the unused field with noise so every input bit toggles
  task automatic send_alloc(input req_t req);
    send_command(CMD_ALLOC, req, off_t'($urandom));
  endtask

  task automatic send_free(input off_t off);
    send_command(CMD_FREE, req_t'($urandom), off);
  endtask

  // Pick one random command, biased toward frees of runs still held
  task automatic send_random_command();
    int unsigned held;
    int unsigned pick;
    int unsigned alloc_pct;
    int unsigned idx;
    int unsigned sz_pick;
    run_t        run;
    req_t        req;
    held = tracker.held_runs.size();
    alloc_pct = (held < 8) ? 70 : ((held > 60) ? 30 : 50);
    pick = $urandom_range(99);
    if (pick < alloc_pct) begin
      sz_pick = $urandom_range(99);
      if (sz_pick < 70)      req = req_t'($urandom_range(8));
      else if (sz_pick < 90) req = req_t'($urandom_range(128, 9));
      else if (sz_pick < 98) req = req_t'($urandom_range(1024, 129));
      else                   req = req_t'($urandom_range(2047, 1025));
      send_alloc(req);
    end else if (pick < 88 && held > 0) begin
      idx = $urandom_range(held - 1);
      run = tracker.held_runs[idx];
      // Free from the first block mostly, sometimes from inside the run
      if ($urandom_range(3) == 0) send_free(off_t'(run.base + $urandom_range(run.span - 1)));
      else                        send_free(off_t'(run.base));
    end else begin
      send_free(off_t'($urandom_range(TOTAL_BLOCKS - 1)));
    end
  endtask

  // Receiver: random stalls, plus one counted hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 17);
      end
    end
  end

  // Check every result beat taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(out_block_offset, out_status);
    end
  end

  // Main sequence
  initial begin
    steady            = 1'b0;
    hold_pending      = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = CMD_ALLOC;
    in_request_blocks = '0;
    in_free_offset    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: free of nothing on an empty pool, at both ends
    send_free(off_t'(0));
    send_free(off_t'(TOTAL_BLOCKS - 1));
    // Zero counts as one block
    send_alloc(req_t'(0));
    // Too large: whole pool while one block is out, then beyond the pool
    send_alloc(req_t'(TOTAL_BLOCKS));
    send_alloc(req_t'(2047));
    send_alloc(req_t'(TOTAL_BLOCKS + 1));
    send_free(off_t'(0));
    // Whole pool, then nothing left
    send_alloc(req_t'(TOTAL_BLOCKS));
    send_alloc(req_t'(1));
    // Free from inside the whole-pool run
    send_free(off_t'(517));
    // Non-power-of-two sizes round up
    send_alloc(req_t'(3));
    send_alloc(req_t'(5));
    send_alloc(req_t'(TOTAL_BLOCKS - 1));
    send_alloc(req_t'(512));
    send_alloc(req_t'(1));
    send_alloc(req_t'(1));
    // Free inside runs, then double free
    send_free(off_t'(TOTAL_BLOCKS - 1));
    send_free(off_t'(2));
    send_free(off_t'(0));
    send_free(off_t'(9));
    send_free(off_t'(12));
    send_free(off_t'(12));
    send_alloc(req_t'(2));
    send_free(off_t'(341));

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i == 700)  steady = 1'b1;
      if (i == 1000) steady = 1'b0;
      // Receiver holds off while commands keep coming
      if (i == 1300) hold_pending = 1'b1;
      // Sender drops valid and waits for every result before going on
      if (i == 1600) begin
        in_valid <= 1'b0;
        while (tracker.owed_grants.size() != 0) @(negedge clk);
      end
      send_random_command();
    end
    in_valid <= 1'b0;

    // Drain, then give the core a walk's worth of cycles for stray beats
    while (tracker.owed_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (tracker.fail_count == 0) begin
      $display("[buddy_block_allocator_core] OK");
    end else begin
      $display("[buddy_block_allocator_core] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run including the clearing pass
  initial begin
    #5000000;
    $display("[buddy_block_allocator_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_round_pow2.sv
hw/rtl/buddy_block_allocator_core.sv
tb/sv/testbench.sv
